// ----- hw/rtl/rgb565_be_alpha_blend_dot_top_defines.svh -----
// Assertion macros for the checker file of the blend-dot block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef RGB565_BE_ALPHA_BLEND_DOT_TOP_DEFINES_SVH
`define RGB565_BE_ALPHA_BLEND_DOT_TOP_DEFINES_SVH

// Clocked check, muted while reset is applied.
`define RGBAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define RGBAB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rgbab_pkg.sv -----
// Shared types, constants and pixel math for the RGB565 blend-dot block.
// No dependencies.
package rgbab_pkg;

  // parameter defaults
  localparam int unsigned MAX_WIDTH_DEF   = 512;
  localparam int unsigned MAX_HEIGHT_DEF  = 256;
  localparam int unsigned ALPHA_FLOOR_DEF = 16;

  // field widths
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned ADDR_W = 17;
  localparam int unsigned FW_W   = 10;
  localparam int unsigned FH_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 10'd512;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 9'd256;
  localparam logic [PIX_W-1:0] BRUSH_RST        = 16'h0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_CODE   = 2'd2;

  typedef enum logic {
    OP_BLEND = 1'b0,
    OP_STORE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         alpha;
    logic [PIX_W-1:0]   raw_pixel;
  } cmd_t;

  typedef struct packed {
    logic              written;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
  } res_t;

  function automatic logic [PIX_W-1:0] swap16(input logic [PIX_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // dst + floor((src - dst) * alpha / 256), modulo 256
  function automatic logic [7:0] mix(input logic [7:0] dst, input logic [7:0] src,
                                     input logic [7:0] alpha);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    diff = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod = diff * $signed({1'b0, alpha});
    return dst + prod[15:8];
  endfunction

endpackage

// ----- hw/rtl/rgbab_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module rgbab_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rgbab_blend.sv -----
// Blend datapath: unpacks a swapped RGB565 word, mixes toward the brush, repacks.
// Depends on rgbab_pkg.
module rgbab_blend (
  input  logic [rgbab_pkg::PIX_W-1:0] pixel_be_i,
  input  logic [rgbab_pkg::PIX_W-1:0] brush_be_i,
  input  logic [7:0]                  alpha_i,
  output logic [rgbab_pkg::PIX_W-1:0] pixel_be_o
);

  logic [rgbab_pkg::PIX_W-1:0] pix, br;
  logic [7:0] dst_r, dst_g, dst_b, src_r, src_g, src_b;
  logic [7:0] mix_r, mix_g, mix_b;

  always_comb begin
    pix = rgbab_pkg::swap16(pixel_be_i);
    br  = rgbab_pkg::swap16(brush_be_i);
    // stored channels get ones in the low bits
    dst_r = {pix[15:11], 3'b111};
    dst_g = {pix[10:5],  2'b11};
    dst_b = {pix[4:0],   3'b111};
    // brush blue keeps zero low bits
    src_r = {br[15:11], 3'b111};
    src_g = {br[10:5],  2'b11};
    src_b = {br[4:0],   3'b000};
    mix_r = rgbab_pkg::mix(dst_r, src_r, alpha_i);
    mix_g = rgbab_pkg::mix(dst_g, src_g, alpha_i);
    mix_b = rgbab_pkg::mix(dst_b, src_b, alpha_i);
    pixel_be_o = rgbab_pkg::swap16({mix_r[7:3], mix_g[7:2], mix_b[7:3]});
  end

endmodule

// ----- hw/rtl/rgb565_be_alpha_blend_dot_top.sv -----
// Blend-dot engine over a byte-swapped RGB565 frame store (one RAM, one port).
// Sequence: accept in idle, then a calc state (bounds check, address multiply),
// an access state (store write, blend read or reject) and, for a blend, a
// blend state (read data, mix, write back); the result strobe is registered.
// Only one item is in flight; a new one is taken once busy is low. Results cannot be stalled.
// Reset: registers to 512 x 256 frame and zero brush; frame RAM is not cleared.
module rgb565_be_alpha_blend_dot_top #(
  parameter int unsigned MAX_WIDTH   = rgbab_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = rgbab_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned ALPHA_FLOOR = rgbab_pkg::ALPHA_FLOOR_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  rgbab_pkg::cmd_t                     cmd_i,
  // result beats, one per item
  output logic                                done_o,
  output rgbab_pkg::res_t                     res_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rgbab_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rgbab_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CALC   = 2'd1;  // bounds check and address
  localparam logic [1:0] ST_ACCESS = 2'd2;  // store write, or blend read
  localparam logic [1:0] ST_BLEND  = 2'd3;  // read data back, mix, write

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [rgbab_pkg::FW_W-1:0]  frame_width_q;
  logic [rgbab_pkg::FH_W-1:0]  frame_height_q;
  logic [rgbab_pkg::PIX_W-1:0] brush_q;

  // item held for the whole sequence
  rgbab_pkg::cmd_t cmd_q;
  logic            ok_q, ok_d;
  logic [AW-1:0]   addr_q, addr_d;

  // result register
  logic            done_q, done_d;
  rgbab_pkg::res_t res_q, res_d;

  // RAM port
  logic                        ram_en, ram_we;
  logic [rgbab_pkg::PIX_W-1:0] ram_wdata, ram_rdata;
  logic [rgbab_pkg::PIX_W-1:0] blend_val;

  // address stage signals
  logic [rgbab_pkg::FW_W-1:0] w_eff;
  logic [rgbab_pkg::FH_W-1:0] h_eff;
  logic                       x_in, y_in, alpha_low;
  logic [18:0]                row_base;
  logic [19:0]                lin_addr;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Register writes; the host must write only while the engine is idle, the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rgbab_pkg::FRAME_WIDTH_RST;
      frame_height_q <= rgbab_pkg::FRAME_HEIGHT_RST;
      brush_q        <= rgbab_pkg::BRUSH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rgbab_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[rgbab_pkg::FW_W-1:0];
        rgbab_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[rgbab_pkg::FH_W-1:0];
        rgbab_pkg::CFG_BRUSH_CODE:   brush_q        <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Frame size clamped to the store geometry.
  always_comb begin
    w_eff = (32'(frame_width_q) > MAX_WIDTH) ? rgbab_pkg::FW_W'(MAX_WIDTH) : frame_width_q;
    h_eff = (32'(frame_height_q) > MAX_HEIGHT) ? rgbab_pkg::FH_W'(MAX_HEIGHT)
                                                 : frame_height_q;
  end

  // Bounds and alpha checks plus the linear address. A point inside the frame
  // has y below 512 and x below 1024, so narrow slices feed the multiplier.
  always_comb begin
    x_in      = !cmd_q.pos_x[15] && ({1'b0, cmd_q.pos_x[14:0]} < {6'b0, w_eff});
    y_in      = !cmd_q.pos_y[15] && ({1'b0, cmd_q.pos_y[14:0]} < {7'b0, h_eff});
    alpha_low = (cmd_q.opcode == rgbab_pkg::OP_BLEND) && (cmd_q.alpha < 8'(ALPHA_FLOOR));
    row_base  = 19'(w_eff) * 19'(cmd_q.pos_y[8:0]);
    lin_addr  = 20'(row_base) + 20'(cmd_q.pos_x[9:0]);
    ok_d      = x_in && y_in && !alpha_low;
    addr_d    = AW'(lin_addr);
  end

  // Item sequencer. Only one item is in flight, so the blend write back
  // lands before the next item can read the RAM.
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = cmd_q.raw_pixel;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (!ok_q) begin
          done_d  = 1'b1;
          res_d   = '0;
          state_d = ST_IDLE;
        end else if (cmd_q.opcode == rgbab_pkg::OP_STORE) begin
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          done_d  = 1'b1;
          res_d   = '{written: 1'b1,
                      pixel_address: rgbab_pkg::ADDR_W'(addr_q),
                      pixel_value: cmd_q.raw_pixel};
          state_d = ST_IDLE;
        end else begin
          ram_en  = 1'b1;  // fetch the pixel to blend
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = blend_val;
        done_d    = 1'b1;
        res_d     = '{written: 1'b1,
                      pixel_address: rgbab_pkg::ADDR_W'(addr_q),
                      pixel_value: blend_val};
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_CALC) begin
      ok_q   <= ok_d;
      addr_q <= addr_d;
    end
    res_q <= res_d;
  end

  rgbab_ram #(
    .WIDTH (rgbab_pkg::PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rgbab_blend u_blend (
    .pixel_be_i (ram_rdata),
    .brush_be_i (brush_q),
    .alpha_i    (cmd_q.alpha),
    .pixel_be_o (blend_val)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- hw/rtl/rgbab_chk.sv -----
// Port-level checks for the blend-dot engine, bound to the top level.
// Depends on rgbab_pkg and rgb565_be_alpha_blend_dot_top_defines.svh.
`include "rgb565_be_alpha_blend_dot_top_defines.svh"

module rgbab_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input rgbab_pkg::res_t res_o
);

  // an accepted beat keeps the engine busy and gives no result next cycle
  `RGBAB_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !done_o), "accept did not go busy")

  // the result beat comes with the engine already free
  `RGBAB_ASSERT(a_done_idle, done_o |-> !busy, "result beat while busy")

  // one beat per item: never two strobes in a row
  `RGBAB_ASSERT(a_done_single, done_o |=> !done_o, "result strobe repeated")

  // a beat that wrote nothing carries zero address and value
  `RGBAB_ASSERT(a_zero_fields,
    (done_o && !res_o.written) |-> (res_o.pixel_address == '0 && res_o.pixel_value == '0),
    "non-zero fields on empty result")

endmodule

bind rgb565_be_alpha_blend_dot_top rgbab_chk u_rgbab_chk (.*);

// ----- test/rgb565_be_alpha_blend_dot_top_test.sv -----
// Self-checking testbench for the RGB565 blend-dot block (rgb565_be_alpha_blend_dot_top).
// Needs rgbab_pkg for the command and result beat types, opcodes and register indexes.
// Directed beats come first, then random dots under several frame and brush settings.
`timescale 1ns / 100ps

module rgb565_be_alpha_blend_dot_top_test;

  localparam int CLK_PERIOD = 12;
  localparam int MAX_W      = rgbab_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H      = rgbab_pkg::MAX_HEIGHT_DEF;
  localparam int FLOOR      = rgbab_pkg::ALPHA_FLOOR_DEF;
  localparam int DEPTH      = MAX_W * MAX_H;
  localparam int STALL_MAX  = 2000;   // cycles with no beat at all before we give up

  // one row of the directed stimulus; want is only used where typed is set
  typedef struct {
    rgbab_pkg::cmd_t cmd;
    bit              typed;
    rgbab_pkg::res_t want;
  } dot_row_t;

  // one register setting plus the traffic run under it
  typedef struct {
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] brush;
    int          idle;
    int          items;
  } paint_phase_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            start = 1'b0;
  logic            busy;
  rgbab_pkg::cmd_t cmd_i = '0;
  logic            done_o;
  rgbab_pkg::res_t res_o;

  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [rgbab_pkg::CFG_IDX_W-1:0]  cfg_index_i = rgbab_pkg::CFG_FRAME_WIDTH;
  logic [rgbab_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // shadow of the block's registers and frame RAM
  logic [rgbab_pkg::FW_W-1:0]  width_q  = rgbab_pkg::FRAME_WIDTH_RST;
  logic [rgbab_pkg::FH_W-1:0]  height_q = rgbab_pkg::FRAME_HEIGHT_RST;
  logic [rgbab_pkg::PIX_W-1:0] brush_q  = rgbab_pkg::BRUSH_RST;
  logic [rgbab_pkg::PIX_W-1:0] frame_mem [DEPTH];
  bit                          pix_seen  [DEPTH];

  rgbab_pkg::res_t painted_q [$];    // results still owed by the block, oldest first
  int   bad_beats = 0;
  int   quiet_cycles = 0;
  int   idle_pct = 0;     // chance in percent of a gap cycle before each command

  dot_row_t     dot_rows [20];
  paint_phase_t phases [8];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  rgb565_be_alpha_blend_dot_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // oversized registers clamp to the RAM geometry
  function automatic int frame_w();
    return (int'(width_q) > MAX_W) ? MAX_W : int'(width_q);
  endfunction

  function automatic int frame_h();
    return (int'(height_q) > MAX_H) ? MAX_H : int'(height_q);
  endfunction

  // linear address of the dot, or -1 when it falls outside the frame
  function automatic int frame_index(rgbab_pkg::cmd_t c);
    int x, y, w, h;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    w = frame_w();
    h = frame_h();
    if (x < 0 || y < 0 || x >= w || y >= h) return -1;
    return w * y + x;
  endfunction

  function automatic logic [15:0] swap_bytes(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // dst moved toward src by a/256, floor on the signed product
  function automatic logic [7:0] channel_mix(logic [7:0] dst, logic [7:0] src, logic [7:0] a);
    int d;
    d = (int'(src) - int'(dst)) * int'(a);
    return 8'((int'(dst) + (d >>> 8)) & 255);
  endfunction

  // result of one command; updates the shadow RAM when a pixel lands
  function automatic rgbab_pkg::res_t paint_dot(rgbab_pkg::cmd_t c);
    rgbab_pkg::res_t             r;
    int                          a;
    logic [rgbab_pkg::PIX_W-1:0] pix, br, rgb;
    logic [7:0]                  rc, gc, bc;
    r = '0;
    a = frame_index(c);
    if (a < 0) return r;
    if (c.opcode == rgbab_pkg::OP_BLEND && int'(c.alpha) < FLOOR) return r;
    if (c.opcode == rgbab_pkg::OP_STORE) begin
      rgb = c.raw_pixel;
    end else begin
      pix = swap_bytes(frame_mem[a]);
      br  = swap_bytes(brush_q);
      // stored channels get ones in the low bits, brush blue gets zeros
      rc  = channel_mix({pix[15:11], 3'b111}, {br[15:11], 3'b111}, c.alpha);
      gc  = channel_mix({pix[10:5], 2'b11}, {br[10:5], 2'b11}, c.alpha);
      bc  = channel_mix({pix[4:0], 3'b111}, {br[4:0], 3'b000}, c.alpha);
      rgb = swap_bytes({rc[7:3], gc[7:2], bc[7:3]});
    end
    frame_mem[a] = rgb;
    pix_seen[a]  = 1'b1;
    r.written       = 1'b1;
    r.pixel_address = a[rgbab_pkg::ADDR_W-1:0];
    r.pixel_value   = rgb;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dot_row_t dot_row(rgbab_pkg::op_e op, int x, int y, int a, int raw,
                                       int typed, int wr, int addr, int val);
    dot_row_t r;
    r.cmd.opcode          = op;
    r.cmd.pos_x           = x[15:0];
    r.cmd.pos_y           = y[15:0];
    r.cmd.alpha           = a[7:0];
    r.cmd.raw_pixel       = raw[15:0];
    r.typed               = typed[0];
    r.want.written        = wr[0];
    r.want.pixel_address  = addr[rgbab_pkg::ADDR_W-1:0];
    r.want.pixel_value    = val[15:0];
    return r;
  endfunction

  // Random dot: mostly in-frame traffic, much of it near the top-left corner so blends
  // land on pixels painted earlier, some edge hits, some pure noise.
  function automatic rgbab_pkg::cmd_t make_dot();
    rgbab_pkg::cmd_t c;
    int              w, h, kind, x, y, a;
    w    = frame_w();
    h    = frame_h();
    kind = $urandom_range(0, 99);
    c.opcode    = rgbab_pkg::op_e'($urandom_range(0, 1));
    c.alpha     = 8'($urandom_range(0, 255));
    c.raw_pixel = 16'($urandom_range(0, 65535));
    x = $urandom_range(0, 65535) - 32768;
    y = $urandom_range(0, 65535) - 32768;
    if (kind < 85) begin
      c.opcode = (kind % 5 < 2) ? rgbab_pkg::OP_STORE : rgbab_pkg::OP_BLEND;
      if (kind % 7 == 0) c.alpha = 8'($urandom_range(0, FLOOR - 1));
      else c.alpha = 8'($urandom_range(FLOOR, 255));
      if (w == 0 || h == 0) begin
        // empty frame: stay near the origin so only the size check rejects
        x = $urandom_range(0, 600);
        y = $urandom_range(0, 300);
      end else if (kind < 45) begin
        x = $urandom_range(0, ((w < 8) ? w : 8) - 1);
        y = $urandom_range(0, ((h < 4) ? h : 4) - 1);
      end else if (kind < 60) begin
        // last column/row, or one past it
        x = w - 1 + $urandom_range(0, 1);
        y = h - 1 + $urandom_range(0, 1);
      end else begin
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
      end
    end
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    // never blend into a pixel that has not been written yet
    a = frame_index(c);
    if (a >= 0 && c.opcode == rgbab_pkg::OP_BLEND && int'(c.alpha) >= FLOOR && !pix_seen[a])
      c.opcode = rgbab_pkg::OP_STORE;
    return c;
  endfunction

  // Present one command, with random gap cycles first. start is only dropped
  // in a gap, so back-to-back commands keep it high across the edge.
  task automatic send_dot(rgbab_pkg::cmd_t c, bit typed, rgbab_pkg::res_t want);
    rgbab_pkg::res_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // beat taken at this edge
    r = paint_dot(c);
    painted_q.push_back(typed ? want : r);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic wait_results(int extra);
    start <= 1'b0;
    @(posedge clk_i);
    while (painted_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write all three registers, valid held high between beats.
  task automatic write_regs(logic [15:0] w, logic [15:0] h, logic [15:0] b);
    logic [rgbab_pkg::CFG_IDX_W-1:0] idx  [3];
    logic [15:0]                     data [3];
    idx  = '{rgbab_pkg::CFG_FRAME_WIDTH, rgbab_pkg::CFG_FRAME_HEIGHT,
             rgbab_pkg::CFG_BRUSH_CODE};
    data = '{w, h, b};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    width_q  = w[rgbab_pkg::FW_W-1:0];
    height_q = h[rgbab_pkg::FH_W-1:0];
    brush_q  = b;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  // done_o and res_o are sampled at the edge that ends their cycle
  always @(posedge clk_i) begin
    rgbab_pkg::res_t want;
    if (rst_ni) begin
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;

      if (done_o) begin
        if (painted_q.size() == 0) begin
          $display("%0t: result beat with none owed, got %h", $time, res_o);
          bad_beats++;
        end else begin
          want = painted_q.pop_front();
          if (res_o.written !== want.written) begin
            $display("%0t: written exp %0d got %0d", $time, want.written, res_o.written);
            bad_beats++;
          end
          if (res_o.pixel_address !== want.pixel_address) begin
            $display("%0t: pixel_address exp %h got %h", $time,
                     want.pixel_address, res_o.pixel_address);
            bad_beats++;
          end
          if (res_o.pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value exp %h got %h", $time,
                     want.pixel_value, res_o.pixel_value);
            bad_beats++;
          end
        end
      end

      if (quiet_cycles >= STALL_MAX) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_MAX);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Directed beats under reset registers (512 x 256, black brush).
    dot_rows = '{
      dot_row(rgbab_pkg::OP_STORE, 0, 0, 0, 'h1234, 1, 1, 0, 'h1234),
      // bottom-right corner, top address
      dot_row(rgbab_pkg::OP_STORE, 511, 255, 0, 'hFFFF, 1, 1, 'h1FFFF, 'hFFFF),
      // outside on each side, store too
      dot_row(rgbab_pkg::OP_STORE, -1, 0, 0, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 0, -32768, 0, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 512, 0, 0, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 0, 256, 0, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 32767, 32767, 255, 'hFFFF, 1, 0, 0, 0),
      // alpha just under the floor, and zero
      dot_row(rgbab_pkg::OP_BLEND, 0, 0, 15, 0, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_BLEND, 0, 0, 0, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_BLEND, -32768, -32768, 255, 'hFFFF, 1, 0, 0, 0),
      dot_row(rgbab_pkg::OP_BLEND, 512, 255, 255, 0, 1, 0, 0, 0),
      // alpha at the floor and at the top
      dot_row(rgbab_pkg::OP_BLEND, 0, 0, 16, 0, 0, 0, 0, 0),
      dot_row(rgbab_pkg::OP_BLEND, 511, 255, 255, 0, 0, 0, 0, 0),
      dot_row(rgbab_pkg::OP_BLEND, 0, 0, 255, 0, 0, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 5, 3, 0, 'h0000, 1, 1, 1541, 'h0000),
      dot_row(rgbab_pkg::OP_BLEND, 5, 3, 128, 0, 0, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 1, 0, 0, 'hAAAA, 1, 1, 1, 'hAAAA),
      dot_row(rgbab_pkg::OP_BLEND, 1, 0, 200, 'h5555, 0, 0, 0, 0),
      dot_row(rgbab_pkg::OP_STORE, 2, 0, 0, 'h5555, 1, 1, 2, 'h5555),
      dot_row(rgbab_pkg::OP_BLEND, 2, 0, 17, 0, 0, 0, 0, 0)
    };

    // Register settings: tiny, empty, clamped, masked and full frames.
    phases = '{
      '{16'd1,    16'd1,    16'hFFFF, 61, 40},
      '{16'd7,    16'd5,    16'hE3A5, 16, 70},
      '{16'd0,    16'd256,  16'h0000,  0, 30},   // zero width
      '{16'd1023, 16'd511,  16'h1F00, 61, 70},   // clamps to 512 x 256
      '{16'd512,  16'd0,    16'hFFFF, 16, 30},   // zero height
      '{16'hFFFF, 16'hFE03, 16'h00F8,  0, 60},   // upper bits dropped: 1023 x 3
      '{16'd33,   16'd17,   16'hB6D9, 61, 70},
      '{16'd512,  16'd256,  16'h5A3C, 16, 100}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 0;
    foreach (dot_rows[i]) send_dot(dot_rows[i].cmd, dot_rows[i].typed, dot_rows[i].want);
    repeat (60) send_dot(make_dot(), 1'b0, '0);

    foreach (phases[p]) begin
      // registers only change with the block drained and settled
      wait_results(4);
      write_regs(phases[p].width, phases[p].height, phases[p].brush);
      idle_pct = phases[p].idle;
      for (int i = 0; i < phases[p].items; i++) begin
        // one full drain in the middle of the last phase
        if (p == 7 && i == phases[p].items / 2) wait_results(0);
        send_dot(make_dot(), 1'b0, '0);
      end
    end

    wait_results(8);
    if (bad_beats == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rgbab_pkg.sv
hw/rtl/rgbab_ram.sv
hw/rtl/rgbab_blend.sv
hw/rtl/rgb565_be_alpha_blend_dot_top.sv
hw/rtl/rgbab_chk.sv
test/rgb565_be_alpha_blend_dot_top_test.sv
